[design/dlrq_pkg.sv]
// Package for the display line refresh queue: transfer types, queue control
// structs, byte codes and mode codes. Depends on nothing.
`default_nettype none

package dlrq_pkg;

    // Input modes.
    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_TX    = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Bytes of the terminal protocol.
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] O_BYTE     = 8'h4F;
    localparam logic [7:0] ONE_BYTE   = 8'h01;
    localparam logic [7:0] FF_BYTE    = 8'h0C;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Positions of the line header, text follows at HEAD_BYTES.
    localparam int POS_ESC    = 0;
    localparam int POS_O      = 1;
    localparam int POS_ONE    = 2;
    localparam int POS_ROW    = 3;
    localparam int HEAD_BYTES = 4;

    // Widest row index and queue count over the supported row range.
    localparam int ROW_IDX_W = 4;
    localparam int QCNT_W    = 5;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] row;
        logic [7:0] text_char;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       line_done;
    } result_t;

    typedef struct packed {
        logic                 enq;
        logic                 clear;
        logic [ROW_IDX_W-1:0] row;
    } queue_cmd_t;

    typedef struct packed {
        logic [QCNT_W-1:0]    count_post;
        logic [ROW_IDX_W-1:0] head_post;
        logic [ROW_IDX_W-1:0] second_post;
        logic                 head_hit;
    } queue_stat_t;

endpackage

`default_nettype wire

[design/display_line_refresh_queue.sv]
// Display line refresh queue: text row store, row queue and line byte sender.
// Depends on dlrq_pkg, dlrq_queue and dlrq_ram.
//
// Usage: an item (mode, row, text_char) is transferred at a rising edge where
// start is high and busy is low. busy is always low, so one item can be
// transferred in every cycle. Mode 0 writes a character into a row at the
// shared write column; a zero character ends the line, queues the row and
// sends the next byte of the head row. Mode 1 is a transmitter ready event
// that sends the next byte of the head row once a line has ended and no
// character has been written since. Mode 2 empties the queue and sends a
// form feed. Each item is processed in the cycle after its transfer and its
// result, if any, is registered and is on result for exactly one cycle with
// result_valid high. The rate is one item per cycle, set by the single
// processing stage and the text RAM, whose read is issued ahead from the
// next send position. The receiver cannot stall: every result is taken in
// the cycle it is shown. Reset clears the queue, the row lengths, the send
// position and the write column; the text RAM is not cleared.
`default_nettype none

module display_line_refresh_queue #(
    parameter int ROWS       = 4,
    parameter int COLS       = 20,
    parameter int LINE_BYTES = 24
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire dlrq_pkg::item_t item,
    output logic                 busy,
    output logic                 result_valid,
    output dlrq_pkg::result_t    result
);
    import dlrq_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = $clog2(COLS + 1);
    localparam int PW    = $clog2(LINE_BYTES + 1);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t         item_reg;
    logic          valid_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          send_en_reg;
    logic          send_en_next;
    logic [CW-1:0] wcol_reg;
    logic [CW-1:0] wcol_next;
    logic [CW-1:0] len_reg  [ROWS];
    logic [CW-1:0] len_next [ROWS];
    result_t       result_reg;
    result_t       result_next;
    logic          result_valid_reg;
    logic          result_valid_next;

    queue_cmd_t    qcmd;
    queue_stat_t   qstat;

    logic [RW-1:0] r;
    logic          row_ok;
    logic          text_in;
    logic          text_end;
    logic          clear_in;
    logic          do_send;
    logic          send_fire;
    logic          last_byte;
    logic [PW-1:0] pos_post;
    logic [RW-1:0] head;
    logic [PW-1:0] col;
    logic          text_ok;
    logic [7:0]    text_byte;
    logic [7:0]    line_byte;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    ram_rdata;
    logic          wr_en_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    wr_data_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [RW-1:0] head_n;
    logic [PW-1:0] col_n;

    assign busy = 1'b0;

    // Item decode.
    assign r        = RW'(item_reg.row - 3'd1);
    assign row_ok   = (item_reg.row != 3'd0) && (32'(item_reg.row) <= ROWS);
    assign text_in  = valid_reg && (item_reg.mode == MODE_TEXT) && row_ok;
    assign text_end = text_in && (item_reg.text_char == 8'd0);
    assign clear_in = valid_reg && (item_reg.mode == MODE_CLEAR);
    assign do_send  = text_end
                      || (valid_reg && (item_reg.mode == MODE_TX) && send_en_reg);

    assign qcmd.enq   = text_end;
    assign qcmd.clear = clear_in;
    assign qcmd.row   = ROW_IDX_W'(r);

    dlrq_queue #(
        .ROWS (ROWS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qcmd),
        .pop   (last_byte),
        .stat  (qstat)
    );

    // A rewrite of the head row restarts it once its text has been reached.
    assign pos_post  = (text_end && qstat.head_hit && (32'(pos_reg) >= HEAD_BYTES))
                       ? '0 : pos_reg;
    assign send_fire = do_send && (qstat.count_post != '0)
                       && (32'(pos_post) < LINE_BYTES);
    assign last_byte = send_fire && ((32'(pos_post) + 1) == LINE_BYTES);

    assign head    = RW'(qstat.head_post);
    assign col     = pos_post - PW'(HEAD_BYTES);
    assign text_ok = (32'(pos_post) >= HEAD_BYTES) && (32'(col) < COLS)
                     && (32'(col) < 32'(len_reg[head]));

    // The RAM read was issued last cycle; a write made at that same edge is
    // forwarded since the RAM returns the old contents.
    assign text_byte = (wr_en_reg && (wr_addr_reg == rd_addr_reg))
                       ? wr_data_reg : ram_rdata;

    always_comb
    begin
        case (32'(pos_post))
            POS_ESC: line_byte = ESC_BYTE;
            POS_O:   line_byte = O_BYTE;
            POS_ONE: line_byte = ONE_BYTE;
            POS_ROW: line_byte = 8'(32'(head) + 1);
            default: line_byte = text_ok ? text_byte : SPACE_BYTE;
        endcase
    end

    always_comb
    begin
        pos_next          = pos_post;
        send_en_next      = send_en_reg;
        wcol_next         = wcol_reg;
        len_next          = len_reg;
        wr_en             = 1'b0;
        wr_addr           = AW'(32'(r) * COLS + 32'(wcol_reg));
        result_valid_next = 1'b0;
        result_next       = '0;
        if (text_in)
        begin
            send_en_next = 1'b0;
            if (item_reg.text_char != 8'd0)
            begin
                if (32'(wcol_reg) < COLS)
                begin
                    wr_en     = 1'b1;
                    wcol_next = wcol_reg + CW'(1);
                end
            end
            else
            begin
                len_next[r]  = wcol_reg;
                wcol_next    = '0;
                send_en_next = 1'b1;
            end
        end
        if (send_fire)
        begin
            result_valid_next     = 1'b1;
            result_next.tx_byte   = line_byte;
            result_next.line_done = last_byte;
            pos_next              = last_byte ? '0 : pos_post + PW'(1);
        end
        if (clear_in)
        begin
            pos_next              = '0;
            result_valid_next     = 1'b1;
            result_next.tx_byte   = FF_BYTE;
            result_next.line_done = 1'b0;
        end
    end

    // Prefetch address of the text byte that the next item would send.
    assign head_n  = last_byte ? RW'(qstat.second_post) : head;
    assign col_n   = pos_next - PW'(HEAD_BYTES);
    assign rd_addr = ((32'(pos_next) >= HEAD_BYTES) && (32'(col_n) < COLS))
                     ? AW'(32'(head_n) * COLS + 32'(col_n)) : '0;

    dlrq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (item_reg.text_char),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            pos_reg          <= '0;
            send_en_reg      <= 1'b0;
            wcol_reg         <= '0;
            result_valid_reg <= 1'b0;
            wr_en_reg        <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg        <= start && !busy;
            pos_reg          <= pos_next;
            send_en_reg      <= send_en_next;
            wcol_reg         <= wcol_next;
            result_valid_reg <= result_valid_next;
            wr_en_reg        <= wr_en;
            len_reg          <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        result_reg  <= result_next;
        wr_addr_reg <= wr_addr;
        wr_data_reg <= item_reg.text_char;
        rd_addr_reg <= rd_addr;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < LINE_BYTES)
        else $error("send position past the line");

    a_wcol_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wcol_reg) <= COLS)
        else $error("write column past the row width");

    a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.line_done) |-> (pos_reg == '0))
        else $error("line end did not rewind the send position");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(valid_reg))
        else $error("result without a processed item");

endmodule

`default_nettype wire

[design/dlrq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module dlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/dlrq_queue.sv]
// Queue of rows waiting to be sent, without duplicates.
// Depends on dlrq_pkg for the command and status structs.
`default_nettype none

module dlrq_queue #(
    parameter int ROWS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dlrq_pkg::queue_cmd_t cmd,
    input  wire logic                 pop,
    output dlrq_pkg::queue_stat_t     stat
);
    import dlrq_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QW = $clog2(ROWS + 1);

    logic [RW-1:0] q_reg  [ROWS];
    logic [RW-1:0] q_post [ROWS];
    logic [RW-1:0] q_next [ROWS];
    logic [QW-1:0] cnt_reg;
    logic [QW-1:0] cnt_post;
    logic [QW-1:0] cnt_next;
    logic [RW-1:0] r;
    logic          hit;
    logic          present;

    assign r = RW'(cmd.row);

    // Enqueue is applied first; the send that follows sees the result.
    always_comb
    begin
        q_post   = q_reg;
        cnt_post = cnt_reg;
        hit      = (cnt_reg != '0) && (q_reg[0] == r);
        present  = 1'b0;
        for (int i = 1; i < ROWS; i++)
        begin
            if ((QW'(i) < cnt_reg) && (q_reg[i] == r))
            begin
                present = 1'b1;
            end
        end
        if (cmd.enq)
        begin
            if (cnt_reg == '0)
            begin
                q_post[0] = r;
                cnt_post  = QW'(1);
            end
            else if (!hit && !present && (cnt_reg < QW'(ROWS)))
            begin
                for (int i = 0; i < ROWS; i++)
                begin
                    if (QW'(i) == cnt_reg)
                    begin
                        q_post[i] = r;
                    end
                end
                cnt_post = cnt_reg + QW'(1);
            end
        end
    end

    always_comb
    begin
        q_next   = q_post;
        cnt_next = cnt_post;
        if (pop)
        begin
            for (int i = 0; i < ROWS - 1; i++)
            begin
                q_next[i] = q_post[i + 1];
            end
            cnt_next = cnt_post - QW'(1);
        end
        if (cmd.clear)
        begin
            cnt_next = '0;
        end
    end

    assign stat.count_post  = QCNT_W'(cnt_post);
    assign stat.head_post   = ROW_IDX_W'(q_post[0]);
    assign stat.second_post = ROW_IDX_W'(q_post[(ROWS > 1) ? 1 : 0]);
    assign stat.head_hit    = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Entries hold no meaning beyond the count, so they take no reset.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QW'(ROWS))
        else $error("queue count above row count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_post != '0))
        else $error("pop from an empty queue");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (cnt_reg == '0))
        else $error("clear left rows in the queue");

endmodule

`default_nettype wire
